FILE: design/all_pairs_shortest_path_core_defines.svh
// ----------------------------------------------------------------------------
// all pairs shortest path core: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_CORE_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define APSP_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("apsp check failed");

// condition implies consequence in the next cycle
`define APSP_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("apsp check failed");

`endif

FILE: design/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg
// Sizes and the matrix entry layout shared by the shortest path core.
// ----------------------------------------------------------------------------
package apsp_pkg;

	localparam int VERTS    = 32;
	localparam int IDX_W    = $clog2(VERTS);
	localparam int ADDR_W   = 2 * IDX_W;
	localparam int DEPTH    = VERTS * VERTS;
	localparam int CNT_W    = IDX_W + 1;
	localparam int DIST_W   = 24;
	localparam int WEIGHT_W = 16;

	// one distance matrix entry with its reachable and predecessor flags
	typedef struct packed {
		logic              ok;
		logic [DIST_W-1:0] cost;
		logic              pok;
		logic [IDX_W-1:0]  pred;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/apsp_ram.sv
// ----------------------------------------------------------------------------
// apsp_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module apsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/apsp_cell.sv
// ----------------------------------------------------------------------------
// apsp_cell
// One cell of the pivot row ring: holds one entry of the pivot row and
// passes it to its neighbor on every shift; the tail cell takes the wrap.
// ----------------------------------------------------------------------------
module apsp_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            tail,
	input  apsp_pkg::entry_t neighbor,
	input  apsp_pkg::entry_t wrap,
	output apsp_pkg::entry_t entry
);

	apsp_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= tail ? wrap : neighbor;
		end
	end

	assign entry = entry_q;

endmodule

FILE: design/all_pairs_shortest_path_core.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core
// Floyd-Warshall shortest path engine with edge load, run and pair read.
// ----------------------------------------------------------------------------
// After reset the weight matrix is cleared one entry a cycle, all 1024 entries,
// while no item is taken. A load or an unused operation is answered straight
// from the result register; a read also waits on the registered read of the
// distance RAM, and no new item is taken until it returns. A run first copies
// the weights into the distance matrix, then for each pivot k loads row k into
// a ring of cells and, for each row i, fetches d[i][k] and streams row i past
// the ring head, one entry relaxed per cycle through the single distance RAM
// port pair.
module all_pairs_shortest_path_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  operation,
	input  logic [4:0]  row,
	input  logic [4:0]  col,
	input  logic [15:0] weight,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [23:0] distance,
	output logic        reachable,
	output logic [4:0]  predecessor,
	output logic        has_predecessor,
	output logic        finished
);

	`include "all_pairs_shortest_path_core_defines.svh"

	localparam int IDX_W    = apsp_pkg::IDX_W;
	localparam int ADDR_W   = apsp_pkg::ADDR_W;
	localparam int CNT_W    = apsp_pkg::CNT_W;
	localparam int DIST_W   = apsp_pkg::DIST_W;
	localparam int WEIGHT_W = apsp_pkg::WEIGHT_W;
	localparam int VERTS    = apsp_pkg::VERTS;

	localparam logic REG_VERTEX_COUNT = 1'b0;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_RUN  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_INIT,
		K_LOAD,
		K_IK,
		K_RELAX,
		K_READ
	} kind_t;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_INIT  = 9'b000000100,
		ST_GAP   = 9'b000001000,
		ST_LOADK = 9'b000010000,
		ST_FETCH = 9'b000100000,
		ST_SWEEP = 9'b001000000,
		ST_DONE  = 9'b010000000,
		ST_READ  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [5:0]        vertex_count_q;
	logic [ADDR_W-1:0] clr_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q;
	logic              computed_q;
	logic [CNT_W-1:0]  run_count_q;

	logic              s1_valid_q;
	kind_t             s1_kind_q;
	logic [ADDR_W-1:0] s1_addr_q;
	logic              s1_flag_q;
	apsp_pkg::entry_t  dik_q;

	logic              result_valid_q;
	logic [DIST_W-1:0] distance_q;
	logic              reachable_q;
	logic [IDX_W-1:0]  predecessor_q;
	logic              has_predecessor_q;
	logic              finished_q;

	logic              cfg_wr;
	logic [CNT_W-1:0]  n_act;
	logic [IDX_W-1:0]  n_last;
	logic              item_accept;
	op_t               op;
	logic              load_hit, read_hit;

	logic                w_we;
	logic [ADDR_W-1:0]   w_waddr;
	logic [WEIGHT_W-1:0] w_wdata, w_rdata;
	logic                w_re;

	logic                        d_we, d_re;
	logic [ADDR_W-1:0]           d_waddr, d_raddr;
	apsp_pkg::entry_t            d_wentry, cur;
	logic [apsp_pkg::ENTRY_W-1:0] d_rdata;

	apsp_pkg::entry_t  head, wrap, relax_entry, init_entry;
	apsp_pkg::entry_t  chain [VERTS];
	logic              chain_shift;
	logic [DIST_W:0]   sum_s;
	logic              relax_take;
	logic              s1_read, load_out, ring_issue;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {26'd0, vertex_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= 6'd32;
		end else if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
			vertex_count_q <= pwdata[5:0];
		end
	end

	assign n_act  = (CNT_W'(vertex_count_q) > CNT_W'(VERTS)) ? CNT_W'(VERTS)
	                                                         : CNT_W'(vertex_count_q);
	assign n_last = IDX_W'(n_act - 1'b1);

	assign op          = op_t'(operation);
	assign item_stall  = (state_q != ST_IDLE) || (result_valid_q && result_stall);
	assign item_accept = item_valid && !item_stall;
	assign load_hit    = ({1'b0, row} < n_act) && ({1'b0, col} < n_act);
	assign read_hit    = computed_q && ({1'b0, row} < run_count_q)
	                     && ({1'b0, col} < run_count_q);

	// weight matrix
	assign w_we    = (state_q == ST_CLEAR) || (item_accept && op == OP_LOAD && load_hit);
	assign w_waddr = (state_q == ST_CLEAR) ? clr_q : {row, col};
	assign w_wdata = (state_q == ST_CLEAR) ? '0 : weight;
	assign w_re    = (state_q == ST_INIT);

	apsp_ram #(.WIDTH(WEIGHT_W), .DEPTH(apsp_pkg::DEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (w_re),
		.raddr ({i_q, j_q}),
		.rdata (w_rdata)
	);

	// distance and predecessor matrix
	assign ring_issue = (state_q == ST_LOADK) || (state_q == ST_FETCH) || (state_q == ST_SWEEP);
	assign d_re = ring_issue || (item_accept && op == OP_READ);

	always_comb begin
		unique case (state_q)
			ST_LOADK: d_raddr = {k_q, j_q};
			ST_FETCH: d_raddr = {i_q, k_q};
			ST_SWEEP: d_raddr = {i_q, j_q};
			default:  d_raddr = {row, col};
		endcase
	end

	assign cur  = apsp_pkg::entry_t'(d_rdata);
	assign head = chain[0];

	// relaxation at the ring head
	assign sum_s      = {1'b0, dik_q.cost} + {1'b0, head.cost};
	assign relax_take = dik_q.ok && head.ok && (!cur.ok || {1'b0, cur.cost} > sum_s);

	always_comb begin
		relax_entry.ok   = 1'b1;
		relax_entry.cost = sum_s[DIST_W-1:0];
		relax_entry.pok  = head.pok;
		relax_entry.pred = head.pred;
	end

	// initial entry from the weight; diagonal without edge is distance zero
	always_comb begin
		init_entry.ok   = (w_rdata != '0) || s1_flag_q;
		init_entry.cost = (w_rdata != '0) ? {{(DIST_W-WEIGHT_W){1'b0}}, w_rdata} : '0;
		init_entry.pok  = (w_rdata != '0);
		init_entry.pred = (w_rdata != '0) ? s1_addr_q[ADDR_W-1:IDX_W] : '0;
	end

	assign d_we     = s1_valid_q && ((s1_kind_q == K_INIT) || (s1_kind_q == K_RELAX && relax_take));
	assign d_waddr  = s1_addr_q;
	assign d_wentry = (s1_kind_q == K_INIT) ? init_entry : relax_entry;

	apsp_ram #(.WIDTH(apsp_pkg::ENTRY_W), .DEPTH(apsp_pkg::DEPTH)) u_dist_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wentry),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// pivot row ring
	assign chain_shift = s1_valid_q && (s1_kind_q == K_LOAD || s1_kind_q == K_RELAX);
	assign wrap        = (s1_kind_q == K_LOAD) ? cur : head;

	for (genvar m = 0; m < VERTS; m++) begin : g_cell
		if (m == VERTS - 1) begin : g_end
			apsp_cell u_cell (
				.clk      (clk),
				.shift    (chain_shift),
				.tail     (IDX_W'(m) == n_last),
				.neighbor (wrap),
				.wrap     (wrap),
				.entry    (chain[m])
			);
		end else begin : g_mid
			apsp_cell u_cell (
				.clk      (clk),
				.shift    (chain_shift),
				.tail     (IDX_W'(m) == n_last),
				.neighbor (chain[m+1]),
				.wrap     (wrap),
				.entry    (chain[m])
			);
		end
	end

	// read stage tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= w_re || d_re;
		end
	end

	always_ff @(posedge clk) begin
		s1_flag_q <= 1'b0;
		unique case (state_q)
			ST_INIT: begin
				s1_kind_q <= K_INIT;
				s1_addr_q <= {i_q, j_q};
				s1_flag_q <= (i_q == j_q);
			end
			ST_LOADK: s1_kind_q <= K_LOAD;
			ST_FETCH: s1_kind_q <= K_IK;
			ST_SWEEP: begin
				s1_kind_q <= K_RELAX;
				s1_addr_q <= {i_q, j_q};
			end
			default: begin
				s1_kind_q <= K_READ;
				s1_flag_q <= read_hit;
			end
		endcase
		if (s1_valid_q && s1_kind_q == K_IK) begin
			dik_q <= cur;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			computed_q  <= 1'b0;
			run_count_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
					if (item_accept && op == OP_RUN) begin
						computed_q  <= 1'b1;
						run_count_q <= n_act;
						state_q     <= (n_act == '0) ? ST_DONE : ST_INIT;
					end else if (item_accept && op == OP_READ) begin
						state_q <= ST_READ;
					end
				end
				ST_INIT: begin
					if (j_q == n_last) begin
						j_q <= '0;
						if (i_q == n_last) begin
							i_q     <= '0;
							state_q <= ST_GAP;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				// lets the last initial write land before row zero is read
				ST_GAP: state_q <= ST_LOADK;
				ST_LOADK: begin
					if (j_q == n_last) begin
						j_q     <= '0;
						state_q <= ST_FETCH;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_FETCH: state_q <= ST_SWEEP;
				ST_SWEEP: begin
					if (j_q == n_last) begin
						j_q <= '0;
						if (i_q == n_last) begin
							i_q <= '0;
							if (k_q == n_last) begin
								state_q <= ST_DONE;
							end else begin
								k_q     <= k_q + 1'b1;
								state_q <= ST_LOADK;
							end
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				ST_READ: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	assign s1_read  = s1_valid_q && s1_kind_q == K_READ;
	assign load_out = (item_accept && op != OP_RUN && op != OP_READ)
	                  || (state_q == ST_DONE) || s1_read;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			distance_q        <= '0;
			reachable_q       <= 1'b0;
			predecessor_q     <= '0;
			has_predecessor_q <= 1'b0;
			finished_q        <= 1'b0;
			if (state_q == ST_DONE) begin
				finished_q <= 1'b1;
			end else if (s1_read) begin
				if (s1_flag_q && cur.ok) begin
					distance_q        <= cur.cost;
					reachable_q       <= 1'b1;
					predecessor_q     <= cur.pok ? cur.pred : '0;
					has_predecessor_q <= cur.pok;
				end
			end else begin
				finished_q <= (op == OP_LOAD) && load_hit;
			end
		end
	end

	assign result_valid    = result_valid_q;
	assign distance        = distance_q;
	assign reachable       = reachable_q;
	assign predecessor     = predecessor_q;
	assign has_predecessor = has_predecessor_q;
	assign finished        = finished_q;

	// a write never lands on the address being read in the same cycle
	`APSP_ASSERT_NOW(a_no_rw_clash, d_we && d_re, d_waddr != d_raddr)
	// the end of a run always leaves an acknowledge waiting
	`APSP_ASSERT_NEXT(a_run_ack, state_q == ST_DONE, result_valid_q && finished_q)
	// read data is turned into a result in the cycle it returns
	`APSP_ASSERT_NEXT(a_read_out, s1_read, result_valid_q && !finished_q)

endmodule
